// File: src/clh_pkg.sv
// Shared types and constants of the command latency histogram.
package clh_pkg;

	localparam int KINDS_DEF      = 256;
	localparam int BOUNDARIES_DEF = 16;
	localparam int QUEUE_DEPTH    = 2;

	localparam int KIND_W = 10;
	localparam int BIN_W  = 5;
	localparam int TICK_W = 64;
	localparam int CNT_W  = 64;

	typedef enum logic [1:0] {
		OP_RECORD = 2'd0,
		OP_READ   = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_WBOUND = 2'd3
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [KIND_W-1:0]  kind;
		logic [TICK_W-1:0]  data;
		logic [BIN_W-1:0]   bin;
	} cmd_t;

	typedef struct packed {
		logic [BIN_W-1:0]  chosen_bin;
		logic [CNT_W-1:0]  call_count;
		logic [CNT_W-1:0]  latency_total;
		logic [CNT_W-1:0]  bin_count;
	} res_t;

	typedef struct packed {
		logic init_busy;
	} back_stat_t;

endpackage

// File: src/clh_fifo.sv
// Small register queue used between the front, the back and the result port.
module clh_fifo import clh_pkg::*; #(
	parameter int WIDTH = 1,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// File: src/clh_front.sv
// Front part: accepts request words, resolves the kind and builds commands.
module clh_front import clh_pkg::*; #(
	parameter int KINDS      = KINDS_DEF,
	parameter int BOUNDARIES = BOUNDARIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         req_type,
	input  logic [15:0]        kind,
	input  logic [TICK_W-1:0]  sample_ticks,
	input  logic [BIN_W-1:0]   bin_index,
	input  logic [TICK_W-1:0]  boundary_ticks,
	input  logic               cfg_we,
	input  logic [KIND_W-1:0]  cfg_data,
	input  back_stat_t         stat,
	input  logic               q_full,
	output logic               q_push,
	output cmd_t               q_data
);

	logic [KIND_W-1:0] fallback_q;
	logic [KIND_W-1:0] fb_res;
	logic [KIND_W-1:0] kind_res;
	logic [BIN_W-1:0]  bin_sel;
	op_t               op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fallback_q <= '0;
		end else if (cfg_we) begin
			fallback_q <= cfg_data;
		end
	end

	always_comb begin
		op = op_t'(req_type);
		if ({1'b0, fallback_q} >= (KIND_W + 1)'(KINDS)) begin
			fb_res = KIND_W'(KINDS - 1);
		end else begin
			fb_res = fallback_q;
		end
		if (kind >= 16'(KINDS)) begin
			kind_res = fb_res;
		end else begin
			kind_res = kind[KIND_W-1:0];
		end
		if (op == OP_READ && bin_index > BIN_W'(BOUNDARIES)) begin
			bin_sel = BIN_W'(BOUNDARIES);
		end else begin
			bin_sel = bin_index;
		end
	end

	assign full        = q_full || stat.init_busy;
	assign q_push      = push && !full;
	assign q_data.op   = op;
	assign q_data.kind = kind_res;
	assign q_data.data = (op == OP_WBOUND) ? boundary_ticks : sample_ticks;
	assign q_data.bin  = bin_sel;

endmodule

// File: src/clh_back.sv
// Back part: counter memories, bin search and the clearing sweep.
module clh_back import clh_pkg::*; #(
	parameter int KINDS      = KINDS_DEF,
	parameter int BOUNDARIES = BOUNDARIES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	output logic       q_pop,
	input  cmd_t       q_data,
	output back_stat_t stat,
	input  logic       r_full,
	output logic       r_push,
	output res_t       r_data
);

	localparam int NBINS = BOUNDARIES + 1;
	localparam int KW    = $clog2(KINDS);
	localparam int BW    = $clog2(NBINS);
	localparam int SW    = (BOUNDARIES > 1) ? $clog2(BOUNDARIES) : 1;
	localparam int AW    = $clog2(KINDS * NBINS);
	localparam int ROW_W = 2 * CNT_W + NBINS;

	typedef enum logic [3:0] {
		S_IDLE, S_HINT0, S_HINT1, S_HINT2, S_SRCH,
		S_BIN, S_BRD, S_BUPD, S_SWEEP, S_ZERO
	} state_t;

	state_t         state_q;
	cmd_t           cmd_q;
	logic [BW-1:0]  bin_q;
	logic [SW-1:0]  srch_q;
	logic [KW-1:0]  sweep_q;
	logic [AW-1:0]  addr_q;
	logic           above_q;
	logic           init_q;

	logic [ROW_W-1:0]  row_mem [KINDS];
	logic [BW-1:0]     hint_mem [KINDS];
	logic [TICK_W-1:0] bnd_mem [BOUNDARIES];
	logic [CNT_W-1:0]  bin_mem [KINDS * NBINS];

	logic [ROW_W-1:0]  row_rd;
	logic [BW-1:0]     hint_rd;
	logic [TICK_W-1:0] bnd_rd;
	logic [CNT_W-1:0]  bin_rd;

	logic              row_re, row_we, hint_re, hint_we, bnd_re, bnd_we, bin_re, bin_we;
	logic [KW-1:0]     row_waddr, hint_waddr, rd_kind;
	logic [ROW_W-1:0]  row_wdata;
	logic [BW-1:0]     hint_wdata;
	logic [SW-1:0]     bnd_raddr, bnd_waddr;
	logic [CNT_W-1:0]  bin_wdata;

	logic [KW-1:0]     k_q;
	logic [TICK_W-1:0] t_q;
	logic [BW-1:0]     hint_dec;
	logic              hint_hit;
	logic              found;
	logic              last_slot;
	logic [CNT_W-1:0]  call_rd, sum_rd, call_new, sum_new, bcnt, bcnt_new;
	logic [NBINS-1:0]  mask_rd, mask_new;

	assign k_q       = cmd_q.kind[KW-1:0];
	assign t_q       = cmd_q.data;
	assign rd_kind   = q_data.kind[KW-1:0];
	assign hint_dec  = hint_rd - BW'(1);
	assign hint_hit  = above_q && ((hint_rd == BW'(BOUNDARIES)) || (t_q <= bnd_rd));
	assign found     = (bnd_rd >= t_q);
	assign last_slot = (srch_q == SW'(BOUNDARIES - 1));
	assign call_rd   = row_rd[CNT_W-1:0];
	assign sum_rd    = row_rd[2*CNT_W-1:CNT_W];
	assign mask_rd   = row_rd[ROW_W-1:2*CNT_W];
	assign call_new  = call_rd + CNT_W'(1);
	assign sum_new   = sum_rd + t_q;
	assign bcnt      = mask_rd[bin_q] ? bin_rd : '0;
	assign bcnt_new  = bcnt + CNT_W'(1);
	assign mask_new  = mask_rd | (NBINS'(1) << bin_q);
	assign stat.init_busy = init_q;

	always_ff @(posedge clk) begin
		if (row_we) begin
			row_mem[row_waddr] <= row_wdata;
		end
		if (row_re) begin
			row_rd <= row_mem[rd_kind];
		end
	end

	always_ff @(posedge clk) begin
		if (hint_we) begin
			hint_mem[hint_waddr] <= hint_wdata;
		end
		if (hint_re) begin
			hint_rd <= hint_mem[rd_kind];
		end
	end

	always_ff @(posedge clk) begin
		if (bnd_we) begin
			bnd_mem[bnd_waddr] <= t_q;
		end
		if (bnd_re) begin
			bnd_rd <= bnd_mem[bnd_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (bin_we) begin
			bin_mem[addr_q] <= bin_wdata;
		end
		if (bin_re) begin
			bin_rd <= bin_mem[addr_q];
		end
	end

	always_comb begin
		q_pop      = 1'b0;
		row_re     = 1'b0;
		row_we     = 1'b0;
		row_waddr  = k_q;
		row_wdata  = {mask_new, sum_new, call_new};
		hint_re    = 1'b0;
		hint_we    = 1'b0;
		hint_waddr = k_q;
		hint_wdata = found ? BW'(srch_q) : BW'(BOUNDARIES);
		bnd_re     = 1'b0;
		bnd_raddr  = '0;
		bnd_we     = 1'b0;
		bnd_waddr  = cmd_q.bin[SW-1:0];
		bin_re     = 1'b0;
		bin_we     = 1'b0;
		bin_wdata  = bcnt_new;
		r_push     = 1'b0;
		r_data     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					row_re  = (q_data.op == OP_RECORD) || (q_data.op == OP_READ);
					hint_re = (q_data.op == OP_RECORD);
				end
			end
			S_HINT0: begin
				if (cmd_q.op == OP_RECORD && hint_rd != '0) begin
					bnd_re    = 1'b1;
					bnd_raddr = hint_dec[SW-1:0];
				end
			end
			S_HINT1: begin
				if (hint_rd != BW'(BOUNDARIES)) begin
					bnd_re    = 1'b1;
					bnd_raddr = hint_rd[SW-1:0];
				end
			end
			S_HINT2: begin
				if (!hint_hit) begin
					bnd_re    = 1'b1;
					bnd_raddr = '0;
				end
			end
			S_SRCH: begin
				if (found || last_slot) begin
					hint_we = 1'b1;
				end else begin
					bnd_re    = 1'b1;
					bnd_raddr = srch_q + SW'(1);
				end
			end
			S_BIN: begin
			end
			S_BRD: begin
				bin_re = 1'b1;
			end
			S_BUPD: begin
				if (!r_full) begin
					r_push = 1'b1;
					r_data.chosen_bin = BIN_W'(bin_q);
					if (cmd_q.op == OP_RECORD) begin
						row_we               = 1'b1;
						bin_we               = 1'b1;
						r_data.call_count    = call_new;
						r_data.latency_total = sum_new;
						r_data.bin_count     = bcnt_new;
					end else begin
						r_data.call_count    = call_rd;
						r_data.latency_total = sum_rd;
						r_data.bin_count     = bcnt;
					end
				end
			end
			S_SWEEP: begin
				row_we     = 1'b1;
				row_waddr  = sweep_q;
				row_wdata  = '0;
				hint_we    = init_q;
				hint_waddr = sweep_q;
				hint_wdata = '0;
			end
			S_ZERO: begin
				r_push = !r_full;
			end
			default: begin
			end
		endcase
		if (state_q == S_ZERO && cmd_q.op == OP_WBOUND && !r_full &&
		    cmd_q.bin < BIN_W'(BOUNDARIES)) begin
			bnd_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
			init_q  <= 1'b1;
			sweep_q <= '0;
			srch_q  <= '0;
			bin_q   <= '0;
			above_q <= 1'b0;
			addr_q  <= '0;
			cmd_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						cmd_q <= q_data;
						unique case (q_data.op)
							OP_RECORD, OP_READ: state_q <= S_HINT0;
							OP_CLEAR: begin
								sweep_q <= '0;
								state_q <= S_SWEEP;
							end
							OP_WBOUND: state_q <= S_ZERO;
						endcase
					end
				end
				S_HINT0: begin
					if (cmd_q.op == OP_READ) begin
						bin_q   <= cmd_q.bin[BW-1:0];
						state_q <= S_BIN;
					end else begin
						state_q <= S_HINT1;
					end
				end
				S_HINT1: begin
					above_q <= (hint_rd == '0) || (t_q > bnd_rd);
					state_q <= S_HINT2;
				end
				S_HINT2: begin
					if (hint_hit) begin
						bin_q   <= hint_rd;
						state_q <= S_BIN;
					end else begin
						srch_q  <= '0;
						state_q <= S_SRCH;
					end
				end
				S_SRCH: begin
					if (found) begin
						bin_q   <= BW'(srch_q);
						state_q <= S_BIN;
					end else if (last_slot) begin
						bin_q   <= BW'(BOUNDARIES);
						state_q <= S_BIN;
					end else begin
						srch_q <= srch_q + SW'(1);
					end
				end
				S_BIN: begin
					addr_q  <= AW'(k_q) * AW'(NBINS) + AW'(bin_q);
					state_q <= S_BRD;
				end
				S_BRD: begin
					state_q <= S_BUPD;
				end
				S_BUPD: begin
					if (!r_full) begin
						state_q <= S_IDLE;
					end
				end
				S_SWEEP: begin
					if (sweep_q == KW'(KINDS - 1)) begin
						init_q  <= 1'b0;
						state_q <= init_q ? S_IDLE : S_ZERO;
					end else begin
						sweep_q <= sweep_q + KW'(1);
					end
				end
				S_ZERO: begin
					if (!r_full) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: src/command_latency_histogram.sv
// Top level of the per-kind command latency histogram engine.
// Requests enter through a small command queue and results leave through a small result queue,
// so either side may stall on its own. After reset the engine sweeps its per-kind counter
// and hint memories and holds full high while it does. A record word first checks the kind's
// last-bin hint and, when the hint no longer holds, searches the boundary table one boundary
// per cycle through its single read port; it then reads and updates its bin counter.
// A read word skips the hint and search steps, a boundary write stores its boundary and pushes
// an all-zero result, and a clear sweeps all KINDS rows. Each word passes the command queue.
module command_latency_histogram import clh_pkg::*; #(
	parameter int KINDS      = KINDS_DEF,
	parameter int BOUNDARIES = BOUNDARIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         req_type,
	input  logic [15:0]        kind,
	input  logic [TICK_W-1:0]  sample_ticks,
	input  logic [BIN_W-1:0]   bin_index,
	input  logic [TICK_W-1:0]  boundary_ticks,
	output logic               empty,
	input  logic               pop,
	output logic [BIN_W-1:0]   chosen_bin,
	output logic [CNT_W-1:0]   call_count,
	output logic [CNT_W-1:0]   latency_total,
	output logic [CNT_W-1:0]   bin_count,
	input  logic               cfg_we,
	input  logic [KIND_W-1:0]  cfg_data
);

	back_stat_t stat;
	logic       cq_push, cq_full, cq_pop, cq_empty;
	cmd_t       cq_din, cq_dout;
	logic       rq_push, rq_full;
	res_t       rq_din, rq_dout;

	clh_front #(
		.KINDS      (KINDS),
		.BOUNDARIES (BOUNDARIES)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.req_type       (req_type),
		.kind           (kind),
		.sample_ticks   (sample_ticks),
		.bin_index      (bin_index),
		.boundary_ticks (boundary_ticks),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data),
		.stat           (stat),
		.q_full         (cq_full),
		.q_push         (cq_push),
		.q_data         (cq_din)
	);

	clh_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cq_push),
		.din    (cq_din),
		.full   (cq_full),
		.pop    (cq_pop),
		.dout   (cq_dout),
		.empty  (cq_empty)
	);

	clh_back #(
		.KINDS      (KINDS),
		.BOUNDARIES (BOUNDARIES)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (cq_empty),
		.q_pop   (cq_pop),
		.q_data  (cq_dout),
		.stat    (stat),
		.r_full  (rq_full),
		.r_push  (rq_push),
		.r_data  (rq_din)
	);

	clh_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rq_push),
		.din    (rq_din),
		.full   (rq_full),
		.pop    (pop),
		.dout   (rq_dout),
		.empty  (empty)
	);

	assign chosen_bin    = rq_dout.chosen_bin;
	assign call_count    = rq_dout.call_count;
	assign latency_total = rq_dout.latency_total;
	assign bin_count     = rq_dout.bin_count;

endmodule

// File: dv/command_latency_histogram_checker.sv
// Checker that predicts every result word of the latency histogram engine and compares it.
module command_latency_histogram_checker import clh_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              full,
	input  logic [1:0]        req_type,
	input  logic [15:0]       kind,
	input  logic [TICK_W-1:0] sample_ticks,
	input  logic [BIN_W-1:0]  bin_index,
	input  logic [TICK_W-1:0] boundary_ticks,
	input  logic              empty,
	input  logic              pop,
	input  logic [BIN_W-1:0]  chosen_bin,
	input  logic [CNT_W-1:0]  call_count,
	input  logic [CNT_W-1:0]  latency_total,
	input  logic [CNT_W-1:0]  bin_count,
	input  logic              cfg_we,
	input  logic [KIND_W-1:0] cfg_data,
	output int                mismatches,
	output int                waiting,
	output int                words_checked
);

	localparam int NBINS = BOUNDARIES_DEF + 1;

	logic [CNT_W-1:0]  calls_of [KINDS_DEF];
	logic [CNT_W-1:0]  ticks_of [KINDS_DEF];
	logic [CNT_W-1:0]  hits_of [KINDS_DEF][NBINS];
	logic [BIN_W-1:0]  hint_of [KINDS_DEF];
	logic [TICK_W-1:0] bound_of [BOUNDARIES_DEF];
	logic [KIND_W-1:0] fallback;
	res_t              pending_results[$];
	int                fails;
	int                compared;

	assign mismatches    = fails;
	assign waiting       = pending_results.size();
	assign words_checked = compared;

	task automatic report(string what, logic [63:0] want, logic [63:0] got);
		fails++;
		$display("mismatch %0d: %s expected %h got %h", fails, what, want, got);
	endtask

	function automatic void wipe_counters();
		for (int i = 0; i < KINDS_DEF; i++) begin
			calls_of[i] = '0;
			ticks_of[i] = '0;
			for (int j = 0; j < NBINS; j++)
				hits_of[i][j] = '0;
		end
	endfunction

	function automatic int unsigned owning_kind(logic [15:0] k);
		if (k < KINDS_DEF)
			return k;
		if (fallback < KINDS_DEF)
			return fallback;
		return KINDS_DEF - 1;
	endfunction

	function automatic int unsigned first_bin(logic [TICK_W-1:0] t);
		for (int i = 0; i < BOUNDARIES_DEF; i++)
			if (bound_of[i] >= t)
				return i;
		return BOUNDARIES_DEF;
	endfunction

	function automatic res_t tally_word(op_t op, logic [15:0] k_in, logic [TICK_W-1:0] t,
			logic [BIN_W-1:0] slot, logic [TICK_W-1:0] val);
		res_t r;
		int unsigned k, b;
		r = '0;
		case (op)
			OP_RECORD: begin
				k = owning_kind(k_in);
				calls_of[k] += 1;
				ticks_of[k] += t;
				b = hint_of[k];
				if (b > BOUNDARIES_DEF)
					b = BOUNDARIES_DEF;
				// The hinted bin is kept only when the sample lies inside its interval.
				if ((b != 0 && t <= bound_of[b-1]) || (b != BOUNDARIES_DEF && t > bound_of[b])) begin
					b = first_bin(t);
					hint_of[k] = BIN_W'(b);
				end
				hits_of[k][b] += 1;
				r.chosen_bin    = BIN_W'(b);
				r.call_count    = calls_of[k];
				r.latency_total = ticks_of[k];
				r.bin_count     = hits_of[k][b];
			end
			OP_READ: begin
				k = owning_kind(k_in);
				b = (slot > BOUNDARIES_DEF) ? BOUNDARIES_DEF : slot;
				r.chosen_bin    = BIN_W'(b);
				r.call_count    = calls_of[k];
				r.latency_total = ticks_of[k];
				r.bin_count     = hits_of[k][b];
			end
			OP_CLEAR: begin
				wipe_counters();
			end
			OP_WBOUND: begin
				if (slot < BOUNDARIES_DEF)
					bound_of[slot] = val;
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			wipe_counters();
			for (int i = 0; i < KINDS_DEF; i++)
				hint_of[i] = '0;
			for (int i = 0; i < BOUNDARIES_DEF; i++)
				bound_of[i] = '0;
			fallback = '0;
			pending_results.delete();
			fails    = 0;
			compared = 0;
		end else begin
			if (pop && !empty) begin
				compared++;
				if (pending_results.size() == 0) begin
					report("word with nothing expected, call_count", '0, call_count);
				end else begin
					want = pending_results.pop_front();
					if (chosen_bin !== want.chosen_bin)
						report("chosen_bin", 64'(want.chosen_bin), 64'(chosen_bin));
					if (call_count !== want.call_count)
						report("call_count", want.call_count, call_count);
					if (latency_total !== want.latency_total)
						report("latency_total", want.latency_total, latency_total);
					if (bin_count !== want.bin_count)
						report("bin_count", want.bin_count, bin_count);
				end
			end
			if (cfg_we)
				fallback = cfg_data;
			if (push && !full)
				pending_results.insert(pending_results.size(),
					tally_word(op_t'(req_type), kind, sample_ticks, bin_index,
					boundary_ticks));
		end
	end

endmodule

// File: dv/tb_command_latency_histogram.sv
// Testbench top for the command latency histogram: stimulus, flow control and verdict.
module tb_command_latency_histogram;
	import clh_pkg::*;

	localparam int WORDS_PER_PHASE = 112;
	localparam int HOLD_CYCLES     = 200;

	logic              clk            = 1'b0;
	logic              arst_n         = 1'b0;
	logic              push           = 1'b0;
	logic [1:0]        req_type       = OP_RECORD;
	logic [15:0]       kind           = '0;
	logic [TICK_W-1:0] sample_ticks   = '0;
	logic [BIN_W-1:0]  bin_index      = '0;
	logic [TICK_W-1:0] boundary_ticks = '0;
	logic              pop            = 1'b0;
	logic              cfg_we         = 1'b0;
	logic [KIND_W-1:0] cfg_data       = '0;
	logic              full;
	logic              empty;
	logic [BIN_W-1:0]  chosen_bin;
	logic [CNT_W-1:0]  call_count;
	logic [CNT_W-1:0]  latency_total;
	logic [CNT_W-1:0]  bin_count;
	int                mismatches;
	int                waiting;
	int                words_checked;

	bit                steady   = 1'b0;
	bit                hold_req = 1'b0;
	logic [TICK_W-1:0] bound_copy [BOUNDARIES_DEF];
	logic [TICK_W-1:0] last_ticks = '0;
	int                sent_by_op [4];
	int                stall_cycles;
	int                settings_used;

	command_latency_histogram u_dut (.*);

	command_latency_histogram_checker u_checker (.*);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		bit held;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			pop <= steady || ($urandom_range(99) >= 22);
		end
	end

	task automatic offer(op_t op, logic [15:0] k, logic [TICK_W-1:0] t, logic [BIN_W-1:0] slot,
			logic [TICK_W-1:0] val);
		@(negedge clk);
		while (!steady && $urandom_range(99) < 22) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push           <= 1'b1;
		req_type       <= op;
		kind           <= k;
		sample_ticks   <= t;
		bin_index      <= slot;
		boundary_ticks <= val;
		@(posedge clk);
		while (full) begin
			stall_cycles++;
			@(posedge clk);
		end
		sent_by_op[op]++;
		if (op == OP_WBOUND && slot < BOUNDARIES_DEF)
			bound_copy[slot] = val;
	endtask

	task automatic drain();
		@(negedge clk);
		push <= 1'b0;
		while (waiting != 0)
			@(negedge clk);
	endtask

	task automatic set_fallback(logic [KIND_W-1:0] v);
		drain();
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	function automatic logic [63:0] wide_random();
		return {$urandom, $urandom};
	endfunction

	task automatic random_word();
		int unsigned       pick;
		op_t               op;
		logic [15:0]       k;
		logic [TICK_W-1:0] t;
		logic [BIN_W-1:0]  slot;
		logic [TICK_W-1:0] val;
		pick = $urandom_range(99);
		op = (pick < 64) ? OP_RECORD : (pick < 84) ? OP_READ : (pick < 97) ? OP_WBOUND : OP_CLEAR;
		pick = $urandom_range(99);
		if (pick < 65)
			k = 16'($urandom_range(7));
		else if (pick < 78)
			k = 16'($urandom_range(KINDS_DEF - 1));
		else if (pick < 90)
			k = 16'($urandom);
		else if (pick < 95)
			k = 16'hFFFF;
		else
			k = $urandom_range(1) ? 16'(KINDS_DEF) : 16'(KINDS_DEF - 1);
		pick = $urandom_range(99);
		if (pick < 40) begin
			t = bound_copy[$urandom_range(BOUNDARIES_DEF - 1)];
			case ($urandom_range(2))
				0: t = t - 64'd1;
				1: t = t + 64'd1;
				default: ;
			endcase
		end else if (pick < 60) begin
			t = 64'($urandom_range(2000));
		end else if (pick < 75) begin
			t = wide_random();
		end else if (pick < 83) begin
			t = '0;
		end else if (pick < 90) begin
			t = '1;
		end else begin
			t = last_ticks;
		end
		last_ticks = t;
		slot = BIN_W'($urandom);
		if (op == OP_WBOUND && $urandom_range(4) != 0)
			slot = BIN_W'($urandom_range(BOUNDARIES_DEF - 1));
		pick = $urandom_range(99);
		if (pick < 50)
			val = (64'(slot) + 64'd1) * 64'd1000 + 64'($urandom_range(999));
		else if (pick < 75)
			val = wide_random();
		else
			val = 64'($urandom_range(20000));
		offer(op, k, t, slot, val);
	endtask

	initial begin
		logic [KIND_W-1:0] v;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		set_fallback('0);

		offer(OP_READ, 16'd0, '0, 5'd0, '0);
		for (int i = 0; i < BOUNDARIES_DEF; i++)
			offer(OP_WBOUND, 16'd0, '0, BIN_W'(i),
				(i == BOUNDARIES_DEF - 1) ? 64'hFFFF_FFFF_FFFF_FFFE : 64'(i + 1) * 100);
		offer(OP_WBOUND, 16'd0, '0, 5'd31, '1);
		offer(OP_RECORD, 16'd0, 64'd0, 5'd0, '0);
		offer(OP_RECORD, 16'd0, 64'd100, 5'd0, '0);
		offer(OP_RECORD, 16'd0, 64'd101, 5'd0, '0);
		offer(OP_RECORD, 16'd0, 64'd150, 5'd0, '0);
		offer(OP_RECORD, 16'd300, '1, 5'd0, '0);
		offer(OP_RECORD, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFE, 5'd0, '0);
		offer(OP_RECORD, 16'd255, 64'd1600, 5'd0, '0);
		offer(OP_READ, 16'd0, '0, 5'd31, '0);
		offer(OP_READ, 16'hFFFF, '0, 5'd15, '0);
		offer(OP_CLEAR, 16'd0, '0, 5'd0, '0);
		offer(OP_READ, 16'd0, '0, 5'd1, '0);

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: v = '0;
				1: v = '1;
				2: v = KIND_W'(KINDS_DEF - 1);
				3: v = KIND_W'(KINDS_DEF);
				4: v = KIND_W'(3);
				default: v = KIND_W'($urandom);
			endcase
			set_fallback(v);
			steady   = (p == 1);
			hold_req = (p == 3);
			repeat (WORDS_PER_PHASE) random_word();
		end

		drain();
		repeat (40) @(negedge clk);
		$display("Sent %0d records, %0d reads, %0d clears, %0d boundary writes; %0d fallbacks.",
			sent_by_op[OP_RECORD], sent_by_op[OP_READ], sent_by_op[OP_CLEAR],
			sent_by_op[OP_WBOUND], settings_used);
		$display("Compared %0d result words; input held off by full for %0d cycles.",
			words_checked, stall_cycles);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
